FILE: sv/lph_pkg.sv
package lph_pkg;

	localparam int unsigned NUM_PLANES      = 4;
	localparam int unsigned NUM_BINS        = 100;
	localparam int unsigned PLANE_W         = 2;
	localparam int unsigned BIN_W           = 7;
	localparam int unsigned SAMPLE_W        = 16;
	localparam int unsigned COUNT_W         = 32;
	localparam int unsigned ADDR_W          = PLANE_W + BIN_W;
	localparam int unsigned FILL_W          = 2;
	localparam int unsigned BIN_WIDTH_RAW   = 80;
	localparam int unsigned BIN_LIMIT_RAW   = NUM_BINS * BIN_WIDTH_RAW;
	localparam int unsigned THRESHOLD_RESET = 80;
	// raw / 80 = (raw >> 4) / 5, and x / 5 = (x * 205) >> 10 exactly for x < 1024
	localparam int unsigned FRAC_BITS       = 4;
	localparam int unsigned QUOT_W          = 9;
	localparam int unsigned RECIP_5         = 205;
	localparam int unsigned RECIP_SHIFT     = 10;
	localparam int unsigned PROD_W          = QUOT_W + 8;

	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_READ   = 1'b1
	} cmd_t;

	typedef struct packed {
		logic              valid;
		logic              is_read;
		logic              read_ok;
		logic              do_inc;
		logic              found;
		logic [BIN_W-1:0]  pbin;
		logic [ADDR_W-1:0] addr;
	} lph_req_t;

	typedef struct packed {
		logic               valid;
		logic               found;
		logic [BIN_W-1:0]   pbin;
		logic [COUNT_W-1:0] count;
	} lph_res_t;

	function automatic logic [BIN_W-1:0] bin_of(input logic [SAMPLE_W-1:0] s);
		logic [QUOT_W-1:0] q;
		logic [PROD_W-1:0] prod;
		q    = s[FRAC_BITS +: QUOT_W];
		prod = PROD_W'(q) * PROD_W'(RECIP_5);
		if (s >= SAMPLE_W'(BIN_LIMIT_RAW))
			return BIN_W'(NUM_BINS);
		return prod[RECIP_SHIFT +: BIN_W];
	endfunction

	function automatic logic plane_ok(input logic [PLANE_W-1:0] p);
		return {1'b0, p} < (PLANE_W + 1)'(NUM_PLANES);
	endfunction

endpackage

FILE: sv/lph_in_if.sv
interface lph_in_if;
	import lph_pkg::*;

	logic                valid;
	logic                ready;
	logic                command;
	logic [PLANE_W-1:0]  plane;
	logic                image_start;
	logic [SAMPLE_W-1:0] sample;
	logic [BIN_W-1:0]    read_bin;

	modport source (output valid, command, plane, image_start, sample, read_bin, input ready);
	modport sink (input valid, command, plane, image_start, sample, read_bin, output ready);
endinterface

FILE: sv/lph_out_if.sv
interface lph_out_if;
	import lph_pkg::*;

	logic               valid;
	logic               ready;
	logic               peak_found;
	logic [BIN_W-1:0]   peak_bin;
	logic [COUNT_W-1:0] bin_count;

	modport source (output valid, peak_found, peak_bin, bin_count, input ready);
	modport sink (input valid, peak_found, peak_bin, bin_count, output ready);
endinterface

FILE: sv/lph_cfg_if.sv
interface lph_cfg_if;
	import lph_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

FILE: sv/lph_window.sv
module lph_window (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic                         command,
	input  logic [lph_pkg::PLANE_W-1:0]  plane,
	input  logic                         image_start,
	input  logic [lph_pkg::SAMPLE_W-1:0] sample,
	input  logic [lph_pkg::BIN_W-1:0]    read_bin,
	input  logic                         cfg_we,
	input  logic [lph_pkg::SAMPLE_W-1:0] cfg_data,
	output lph_pkg::lph_req_t            req
);
	import lph_pkg::*;

	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(2);

	logic [SAMPLE_W-1:0] thr_q;
	logic [SAMPLE_W-1:0] middle_q;
	logic [SAMPLE_W-1:0] older_q;
	logic [BIN_W-1:0]    middle_bin_q;
	logic [FILL_W-1:0]   fill_q;
	logic [PLANE_W-1:0]  plane_q;
	logic                is_read;
	logic                peak;

	assign is_read = (command == CMD_READ);
	assign peak = !is_read && !image_start && (fill_q == FILL_FULL) &&
		(older_q < middle_q) && (middle_q > sample) && (middle_q > thr_q);

	always_comb begin
		req.valid   = accept;
		req.is_read = is_read;
		req.read_ok = plane_ok(plane) && (read_bin <= BIN_W'(NUM_BINS));
		req.do_inc  = peak && plane_ok(plane_q);
		req.found   = peak;
		req.pbin    = peak ? middle_bin_q : '0;
		req.addr    = is_read ? {plane, read_bin} : {plane_q, middle_bin_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= SAMPLE_W'(THRESHOLD_RESET);
		end else if (cfg_we) begin
			thr_q <= cfg_data;
		end
	end

	// bin of the middle sample is worked out as it enters the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			middle_q     <= '0;
			older_q      <= '0;
			middle_bin_q <= '0;
			fill_q       <= '0;
			plane_q      <= '0;
		end else if (accept && !is_read) begin
			middle_q     <= sample;
			middle_bin_q <= bin_of(sample);
			if (image_start) begin
				plane_q <= plane;
				older_q <= '0;
				fill_q  <= FILL_W'(1);
			end else begin
				older_q <= middle_q;
				if (fill_q != FILL_FULL)
					fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

endmodule

FILE: sv/lph_hist_mem.sv
module lph_hist_mem (
	input  logic              clk,
	input  logic              arst_n,
	input  lph_pkg::lph_req_t req,
	input  logic              out_free,
	output logic              can_accept,
	output lph_pkg::lph_res_t res
);
	import lph_pkg::*;

	localparam int unsigned DEPTH = 2 ** ADDR_W;

	logic [COUNT_W-1:0] mem [DEPTH];
	logic [COUNT_W-1:0] rd_q;
	logic               clearing_q;
	logic [ADDR_W-1:0]  clr_addr_q;
	lph_req_t           s1;
	logic               wr_valid_q;
	logic [ADDR_W-1:0]  wr_addr_q;
	logic [COUNT_W-1:0] wr_data_q;
	logic [COUNT_W-1:0] cur;
	logic [COUNT_W-1:0] nxt;
	logic               commit_we;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_wa;
	logic [COUNT_W-1:0] mem_wd;

	assign can_accept = !clearing_q && (!s1.valid || out_free);

	// the read issued alongside the last write saw the old count
	assign cur = (wr_valid_q && (wr_addr_q == s1.addr)) ? wr_data_q : rd_q;
	assign nxt = (&cur) ? cur : cur + COUNT_W'(1);
	assign commit_we = s1.valid && s1.do_inc && out_free;

	assign mem_we = clearing_q || commit_we;
	assign mem_wa = clearing_q ? clr_addr_q : s1.addr;
	assign mem_wd = clearing_q ? '0 : nxt;

	always_comb begin
		res.valid = s1.valid;
		res.found = s1.found;
		res.pbin  = s1.pbin;
		res.count = (s1.is_read && s1.read_ok) ? cur : '0;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (req.valid)
			rd_q <= mem[req.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (&clr_addr_q)
				clearing_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1 <= '0;
		end else if (!s1.valid || out_free) begin
			s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_q <= 1'b0;
			wr_addr_q  <= '0;
			wr_data_q  <= '0;
		end else if (commit_we) begin
			wr_valid_q <= 1'b1;
			wr_addr_q  <= s1.addr;
			wr_data_q  <= nxt;
		end
	end

`ifndef SYNTHESIS
	a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !req.valid)
		else $error("item taken during clearing pass");

	a_no_commit_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !(s1.valid && s1.do_inc))
		else $error("count update during clearing pass");

	a_read_never_counts: assert property (@(posedge clk) disable iff (!arst_n)
		s1.valid && s1.is_read |-> !s1.do_inc && !s1.found)
		else $error("read transaction marked as peak");

	a_clear_covers_store: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clearing_q) |-> $past(&clr_addr_q))
		else $error("clearing pass ended early");

	a_held_stage_stable: assert property (@(posedge clk) disable iff (!arst_n)
		s1.valid && !out_free |=> $stable(s1) && $stable(rd_q))
		else $error("stalled stage lost its data");
`endif

endmodule

FILE: sv/local_peak_histogrammer_core.sv
// channel | role   | transaction carries
// cfg     | sink   | peak_threshold write data
// req     | sink   | command, plane, image_start, sample, read_bin
// rsp     | source | peak_found, peak_bin, bin_count
//
// one transaction per cycle sustained while rsp is not stalled; a result passes the count stage and the output register
// rate is set by the histogram read-modify-write: read at accept, write back as the item leaves the count stage
// after reset the histogram store is swept to zero, all 512 addresses, with req.ready low
// cfg is always ready; rsp stalls hold the count stage and stop req at the store port
module local_peak_histogrammer_core (
	input  logic clk,
	input  logic arst_n,
	lph_cfg_if.sink   cfg,
	lph_in_if.sink    req,
	lph_out_if.source rsp
);
	import lph_pkg::*;

	lph_req_t           win_req;
	lph_res_t           s1_res;
	logic               accept;
	logic               can_accept;
	logic               out_free;
	logic               out_valid_q;
	logic               found_q;
	logic [BIN_W-1:0]   pbin_q;
	logic [COUNT_W-1:0] count_q;

	// threshold register takes a write every cycle it is offered
	assign cfg.ready = 1'b1;

	// output register empties or is being drained this cycle
	assign out_free = !out_valid_q || rsp.ready;
	assign req.ready = can_accept;
	assign accept = req.valid && can_accept;

	// sample window, peak test and address generation
	lph_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.command     (req.command),
		.plane       (req.plane),
		.image_start (req.image_start),
		.sample      (req.sample),
		.read_bin    (req.read_bin),
		.cfg_we      (cfg.valid),
		.cfg_data    (cfg.data),
		.req         (win_req)
	);

	// histogram store with clear sweep, increment and forwarding
	lph_hist_mem u_hist_mem (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (win_req),
		.out_free   (out_free),
		.can_accept (can_accept),
		.res        (s1_res)
	);

	// output register parts the count stage from the downstream ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_res.valid;
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (out_free) begin
			found_q <= s1_res.found;
			pbin_q  <= s1_res.pbin;
			count_q <= s1_res.count;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.peak_found = found_q;
	assign rsp.peak_bin   = pbin_q;
	assign rsp.bin_count  = count_q;

endmodule
